// ===== design/kmie_pkg.sv =====
package kmie_pkg;

  // Field widths fixed by the interface
  localparam int OP_W    = 2;
  localparam int ID_W    = 3;
  localparam int CRD_W   = 16;
  localparam int CNT_W   = 16;
  localparam int KCFG_W  = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Number of centroid slots
  localparam int MAX_CLUSTERS = 8;

  // Opcodes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ASSIGN = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
  localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_K      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_Y = 3'd4;

  // Result kinds
  localparam logic KIND_POINT  = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic [ID_W-1:0]         centroid_index;
    logic signed [CRD_W-1:0] coord_x;
    logic signed [CRD_W-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic                    result_kind;
    logic [ID_W-1:0]         cluster_id;
    logic                    no_match;
    logic signed [CRD_W-1:0] centroid_x;
    logic signed [CRD_W-1:0] centroid_y;
    logic [CNT_W-1:0]        member_count;
    logic                    last;
  } out_item_t;

endpackage

// ===== design/kmie_queue.sv =====
// Two-entry queue between the front and the back.
module kmie_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  kmie_pkg::in_item_t wr_data,
  output logic               rd_valid,
  input  logic               rd_ready,
  output kmie_pkg::in_item_t rd_data
);

  kmie_pkg::in_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> (cnt_r == 2'd2))
    else $error("queue lost an entry");

endmodule

// ===== design/kmie_back.sv =====
// Back part: stores loaded centroids, walks the centroids one per cycle for an
// assignment, and runs a serial restoring divider per cluster for an update.
module kmie_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  kmie_pkg::in_item_t                q_data,
  input  logic [kmie_pkg::KCFG_W-1:0]       k_cfg,
  input  logic signed [kmie_pkg::CRD_W-1:0] lo_x,
  input  logic signed [kmie_pkg::CRD_W-1:0] lo_y,
  input  logic signed [kmie_pkg::CRD_W-1:0] hi_x,
  input  logic signed [kmie_pkg::CRD_W-1:0] hi_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output kmie_pkg::out_item_t               out_data
);

  localparam int MAX_CLUSTERS = kmie_pkg::MAX_CLUSTERS;
  localparam int COORD_WIDTH  = kmie_pkg::CRD_W;
  localparam int COUNT_WIDTH  = kmie_pkg::CNT_W;
  localparam int IW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KW   = $clog2(MAX_CLUSTERS + 1);
  localparam int DW   = COORD_WIDTH + 1;
  localparam int SQW  = 2 * DW;
  localparam int DSW  = SQW + 1;
  localparam int SW   = COORD_WIDTH + COUNT_WIDTH;
  localparam int MW   = SW + 1;
  localparam int CSW  = $clog2(SW + 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE, S_DIAG, S_SCAN, S_ACC, S_DIV, S_EMIT
  } state_t;

  state_t state_r;

  // Cluster storage
  logic signed [COORD_WIDTH-1:0] cx_r  [MAX_CLUSTERS];
  logic signed [COORD_WIDTH-1:0] cy_r  [MAX_CLUSTERS];
  logic signed [SW-1:0]          sx_r  [MAX_CLUSTERS];
  logic signed [SW-1:0]          sy_r  [MAX_CLUSTERS];
  logic [COUNT_WIDTH-1:0]        cnt_r [MAX_CLUSTERS];

  kmie_pkg::in_item_t   item_r;
  logic [IW-1:0]        idx_r;
  logic [KW-1:0]        k_r;
  logic [DSW-1:0]       best_r;
  logic [IW-1:0]        best_id_r;
  logic                 found_r;
  logic [DW-1:0]        dx_r, dy_r;
  logic                 dstage_r;
  logic [IW-1:0]        dist_id_r;
  logic [IW-1:0]        issue_r;
  logic                 issue_done_r;
  // Divider
  logic [MW-1:0]        rem_r [2];
  logic [SW-1:0]        quo_r [2];
  logic [SW-1:0]        dvd_r [2];
  logic                 neg_r [2];
  logic [CSW-1:0]       dcnt_r;
  kmie_pkg::out_item_t  out_r;
  logic                 ov_r;

  logic [KW-1:0] k_eff;
  logic [KW-1:0] k_ext;
  logic signed [COORD_WIDTH-1:0] px, py;
  logic [DW-1:0] adx, ady;
  logic [DSW-1:0] dsum;
  logic out_free;
  logic out_load;
  logic [MW-1:0] trial [2];
  logic [SW-1:0] sabs [2];

  assign k_ext = KW'(k_cfg);
  always_comb begin
    if (k_cfg == '0) k_eff = KW'(1);
    else if (32'(k_cfg) > MAX_CLUSTERS) k_eff = KW'(MAX_CLUSTERS);
    else k_eff = k_ext;
  end

  assign px = COORD_WIDTH'(item_r.coord_x);
  assign py = COORD_WIDTH'(item_r.coord_y);
  assign out_free = !ov_r || out_ready;
  assign out_load = ((state_r == S_ACC) || (state_r == S_EMIT)) && out_free;
  assign q_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // Absolute differences: window diagonal in S_DIAG, centroids in S_SCAN
  always_comb begin
    logic signed [DW-1:0] ax, bx, ay, by;
    if (state_r == S_DIAG) begin
      ax = DW'(lo_x); bx = DW'(hi_x); ay = DW'(lo_y); by = DW'(hi_y);
    end else begin
      ax = DW'(px); bx = DW'(cx_r[issue_r]);
      ay = DW'(py); by = DW'(cy_r[issue_r]);
    end
    adx = (ax >= bx) ? DW'(ax - bx) : DW'(bx - ax);
    ady = (ay >= by) ? DW'(ay - by) : DW'(by - ay);
  end

  // Squares of the registered differences
  assign dsum = DSW'(dx_r * dx_r) + DSW'(dy_r * dy_r);

  // Divider trial subtraction
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      trial[j] = {rem_r[j][MW-2:0], dvd_r[j][SW-1]} - MW'(cnt_r[idx_r]);
    end
    sabs[0] = sx_r[idx_r][SW-1] ? SW'(-sx_r[idx_r]) : SW'(sx_r[idx_r]);
    sabs[1] = sy_r[idx_r][SW-1] ? SW'(-sy_r[idx_r]) : SW'(sy_r[idx_r]);
  end

  // Sequencer, storage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ov_r     <= 1'b0;
      dstage_r <= 1'b0;
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cx_r[i] <= '0; cy_r[i] <= '0; sx_r[i] <= '0; sy_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      if (out_load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            item_r <= q_data;
            k_r    <= k_eff;
            idx_r  <= '0;
            if (q_data.opcode == kmie_pkg::OP_LOAD) begin
              if (32'(q_data.centroid_index) < MAX_CLUSTERS) begin
                cx_r[IW'(q_data.centroid_index)] <= COORD_WIDTH'(q_data.coord_x);
                cy_r[IW'(q_data.centroid_index)] <= COORD_WIDTH'(q_data.coord_y);
              end
            end else if (q_data.opcode == kmie_pkg::OP_ASSIGN) begin
              state_r <= S_DIAG;
            end else if (q_data.opcode == kmie_pkg::OP_UPDATE) begin
              state_r <= S_DIV;
              dcnt_r  <= '0;
            end
          end
        end
        S_DIAG: begin
          // Diagonal squared forms the initial bound
          dx_r <= adx; dy_r <= ady;
          if (dstage_r) begin
            best_r <= dsum; found_r <= 1'b0; best_id_r <= '0;
            dstage_r <= 1'b0; issue_r <= '0; issue_done_r <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            dstage_r <= 1'b1;
          end
        end
        S_SCAN: begin
          // Two-stage pipeline: difference, then square and compare
          if (!issue_done_r) begin
            dx_r <= adx; dy_r <= ady; dist_id_r <= issue_r; dstage_r <= 1'b1;
            if (KW'(issue_r) + KW'(1) == k_r) issue_done_r <= 1'b1;
            else issue_r <= issue_r + IW'(1);
          end else begin
            dstage_r <= 1'b0;
          end
          if (dstage_r && dsum < best_r) begin
            best_r <= dsum; best_id_r <= dist_id_r; found_r <= 1'b1;
          end
          if (issue_done_r && !dstage_r) state_r <= S_ACC;
        end
        S_ACC: begin
          if (out_free) begin
            if (found_r && cnt_r[best_id_r] != CNT_MAX) begin
              sx_r[best_id_r] <= sx_r[best_id_r] + SW'(px);
              sy_r[best_id_r] <= sy_r[best_id_r] + SW'(py);
              cnt_r[best_id_r] <= cnt_r[best_id_r] + COUNT_WIDTH'(1);
            end
            out_r.result_kind  <= kmie_pkg::KIND_POINT;
            out_r.cluster_id   <= found_r ? kmie_pkg::ID_W'(best_id_r) : '0;
            out_r.no_match     <= !found_r;
            out_r.centroid_x   <= '0;
            out_r.centroid_y   <= '0;
            out_r.member_count <= '0;
            out_r.last         <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        S_DIV: begin
          // One quotient bit per cycle for both coordinates
          if (dcnt_r == '0) begin
            dvd_r[0] <= sabs[0]; dvd_r[1] <= sabs[1];
            neg_r[0] <= sx_r[idx_r][SW-1]; neg_r[1] <= sy_r[idx_r][SW-1];
            rem_r[0] <= '0; rem_r[1] <= '0;
            dcnt_r <= CSW'(1);
          end else begin
            for (int j = 0; j < 2; j++) begin
              if (!trial[j][MW-1]) begin
                rem_r[j] <= trial[j]; quo_r[j] <= {quo_r[j][SW-2:0], 1'b1};
              end else begin
                rem_r[j] <= {rem_r[j][MW-2:0], dvd_r[j][SW-1]};
                quo_r[j] <= {quo_r[j][SW-2:0], 1'b0};
              end
              dvd_r[j] <= {dvd_r[j][SW-2:0], 1'b0};
            end
            if (32'(dcnt_r) == SW) state_r <= S_EMIT;
            else dcnt_r <= dcnt_r + CSW'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            logic signed [COORD_WIDTH-1:0] nx, ny;
            nx = cx_r[idx_r]; ny = cy_r[idx_r];
            if (cnt_r[idx_r] != '0) begin
              nx = neg_r[0] ? COORD_WIDTH'(-quo_r[0]) : COORD_WIDTH'(quo_r[0]);
              ny = neg_r[1] ? COORD_WIDTH'(-quo_r[1]) : COORD_WIDTH'(quo_r[1]);
            end
            cx_r[idx_r] <= nx; cy_r[idx_r] <= ny;
            out_r.result_kind  <= kmie_pkg::KIND_UPDATE;
            out_r.cluster_id   <= kmie_pkg::ID_W'(idx_r);
            out_r.no_match     <= 1'b0;
            out_r.centroid_x   <= kmie_pkg::CRD_W'(nx);
            out_r.centroid_y   <= kmie_pkg::CRD_W'(ny);
            out_r.member_count <= kmie_pkg::CNT_W'(cnt_r[idx_r]);
            out_r.last         <= (KW'(idx_r) + KW'(1) == k_r);
            dcnt_r <= '0;
            if (KW'(idx_r) + KW'(1) == k_r) begin
              for (int i = 0; i < MAX_CLUSTERS; i++) begin
                sx_r[i] <= '0; sy_r[i] <= '0; cnt_r[i] <= '0;
              end
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r + IW'(1);
              state_r <= S_DIV;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> (ov_r && $stable(out_r)))
    else $error("pending result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && out_free) |=> (ov_r && state_r == S_IDLE))
    else $error("assignment result missing");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !q_ready)
    else $error("took item while busy");

endmodule

// ===== design/kmie_front.sv =====
// Front part: accepts items, drops unused opcodes and holds configuration.
module kmie_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  kmie_pkg::in_item_t                    in_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [kmie_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kmie_pkg::CFG_DAT_W-1:0]        cfg_data,
  output logic                                  q_valid,
  input  logic                                  q_ready,
  output kmie_pkg::in_item_t                    q_data,
  output logic [kmie_pkg::KCFG_W-1:0]           k_cfg,
  output logic signed [kmie_pkg::CRD_W-1:0]     lo_x,
  output logic signed [kmie_pkg::CRD_W-1:0]     lo_y,
  output logic signed [kmie_pkg::CRD_W-1:0]     hi_x,
  output logic signed [kmie_pkg::CRD_W-1:0]     hi_y
);

  logic [kmie_pkg::KCFG_W-1:0]       k_r;
  logic signed [kmie_pkg::CRD_W-1:0] lox_r, loy_r, hix_r, hiy_r;
  logic drop;

  // Opcode 3 is consumed here with no effect
  assign drop     = (in_data.opcode != kmie_pkg::OP_LOAD) &&
                    (in_data.opcode != kmie_pkg::OP_ASSIGN) &&
                    (in_data.opcode != kmie_pkg::OP_UPDATE);
  assign in_ready = drop || q_ready;
  assign q_valid  = in_valid && !drop;
  assign q_data   = in_data;
  assign cfg_ready = 1'b1;
  assign k_cfg = k_r;
  assign lo_x = lox_r; assign lo_y = loy_r;
  assign hi_x = hix_r; assign hi_y = hiy_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= kmie_pkg::KCFG_W'(8);
      lox_r <= 16'sh8000; loy_r <= 16'sh8000;
      hix_r <= 16'sh7fff; hiy_r <= 16'sh7fff;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kmie_pkg::REG_K:      k_r   <= cfg_data[kmie_pkg::KCFG_W-1:0];
        kmie_pkg::REG_LOW_X:  lox_r <= cfg_data;
        kmie_pkg::REG_LOW_Y:  loy_r <= cfg_data;
        kmie_pkg::REG_HIGH_X: hix_r <= cfg_data;
        kmie_pkg::REG_HIGH_Y: hiy_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/kmeans_iteration_engine_unit.sv =====
// Channel | Direction | Payload
// in_     | input     | kmie_pkg::in_item_t (opcode, index, coordinates)
// out_    | output    | kmie_pkg::out_item_t (assignment or centroid)
// cfg_    | input     | register index and 16-bit data
// A point's result passes through the queue, the window bound, the difference
// and square-and-compare stages, and finally the output register.
// An update runs the bit-serial divider once for each cluster; unused opcodes
// are consumed.
// Reset is synchronous and clears every accumulator and centroid at once.
// A stalled output holds the back part while the queue keeps taking items until its two entries are full.
module kmeans_iteration_engine_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  kmie_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output kmie_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kmie_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kmie_pkg::CFG_DAT_W-1:0] cfg_data
);

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  kmie_pkg::in_item_t fq_data, qb_data;
  logic [kmie_pkg::KCFG_W-1:0] k_cfg;
  logic signed [kmie_pkg::CRD_W-1:0] lo_x, lo_y, hi_x, hi_y;

  kmie_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data),
    .k_cfg, .lo_x, .lo_y, .hi_x, .hi_y
  );

  kmie_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );

  kmie_back u_back (
    .clk, .rst_n,
    .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
    .k_cfg, .lo_x, .lo_y, .hi_x, .hi_y,
    .out_valid, .out_ready, .out_data
  );

endmodule
